@@ src/next_fit_block_allocator_top_defines.svh @@
// assertion macros shared by the allocator checker
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define NFBA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("allocator assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define NFBA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator assertion failed");

`endif

@@ src/nfba_pkg.sv @@
// shared types and constants of the next-fit block allocator
package nfba_pkg;

    localparam int SIZE_W     = 21;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 32;

    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam size_t REGION_SIZE_RESET = 21'd65536;

    // register indexes of the configuration port
    localparam logic CFG_REGION_SIZE = 1'b0;
    localparam logic CFG_REGION_BASE = 1'b1;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result codes
    localparam status_t ST_GRANTED      = 3'd0;
    localparam status_t ST_ZERO_SIZE    = 3'd1;
    localparam status_t ST_NO_FIT       = 3'd2;
    localparam status_t ST_FREED        = 3'd3;
    localparam status_t ST_FREE_IGNORED = 3'd4;

    // one row of the block table
    typedef struct packed {
        logic  used;
        size_t size;
        size_t offset;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DISPATCH,
        S_A_ROVER,
        S_A_SCAN,
        S_A_MARK,
        S_A_SHIFT,
        S_A_SPLIT,
        S_F_SCAN,
        S_F_PREV,
        S_F_NEXT,
        S_F_MERGE,
        S_F_SHIFT,
        S_F_DONE,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INIT,
        OP_DISPATCH,
        OP_A_ROVER,
        OP_A_SCAN,
        OP_A_MARK,
        OP_A_SHIFT,
        OP_A_SPLIT,
        OP_F_SCAN,
        OP_F_PREV,
        OP_F_NEXT,
        OP_F_MERGE,
        OP_F_SHIFT,
        OP_F_DONE,
        OP_LOAD
    } op_t;

    // status from datapath to controller
    typedef struct packed {
        logic fresh;
        logic is_free;
        logic want_zero;
        logic fit;
        logic scan_end;
        logic do_split;
        logic match;
        logic used;
        logic shift_more;
        logic slot_free;
    } dp_stat_t;

endpackage

@@ src/nfba_ctrl.sv @@
// controller state machine of the allocator
module nfba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nfba_pkg::dp_stat_t stat,
    output nfba_pkg::op_t      op
);

    nfba_pkg::state_t state_reg;
    nfba_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.fresh ? nfba_pkg::S_INIT : nfba_pkg::S_DISPATCH;
                end
            end
            nfba_pkg::S_INIT:     state_next = nfba_pkg::S_DISPATCH;
            nfba_pkg::S_DISPATCH:
            begin
                if (stat.is_free)
                begin
                    state_next = nfba_pkg::S_F_SCAN;
                end
                else
                begin
                    state_next = stat.want_zero ? nfba_pkg::S_DONE : nfba_pkg::S_A_ROVER;
                end
            end
            nfba_pkg::S_A_ROVER:
            begin
                state_next = stat.fit ? nfba_pkg::S_A_MARK : nfba_pkg::S_A_SCAN;
            end
            nfba_pkg::S_A_SCAN:
            begin
                priority if (stat.fit)
                begin
                    state_next = nfba_pkg::S_A_MARK;
                end
                else if (stat.scan_end)
                begin
                    state_next = nfba_pkg::S_DONE;
                end
            end
            nfba_pkg::S_A_MARK:
            begin
                priority if (!stat.do_split)
                begin
                    state_next = nfba_pkg::S_DONE;
                end
                else if (stat.shift_more)
                begin
                    state_next = nfba_pkg::S_A_SHIFT;
                end
                else
                begin
                    state_next = nfba_pkg::S_A_SPLIT;
                end
            end
            nfba_pkg::S_A_SHIFT:
            begin
                if (!stat.shift_more)
                begin
                    state_next = nfba_pkg::S_A_SPLIT;
                end
            end
            nfba_pkg::S_A_SPLIT:  state_next = nfba_pkg::S_DONE;
            nfba_pkg::S_F_SCAN:
            begin
                priority if (stat.match)
                begin
                    state_next = stat.used ? nfba_pkg::S_F_PREV : nfba_pkg::S_DONE;
                end
                else if (stat.scan_end)
                begin
                    state_next = nfba_pkg::S_DONE;
                end
            end
            nfba_pkg::S_F_PREV:   state_next = nfba_pkg::S_F_NEXT;
            nfba_pkg::S_F_NEXT:   state_next = nfba_pkg::S_F_MERGE;
            nfba_pkg::S_F_MERGE:
            begin
                state_next = stat.shift_more ? nfba_pkg::S_F_SHIFT : nfba_pkg::S_F_DONE;
            end
            nfba_pkg::S_F_SHIFT:
            begin
                if (!stat.shift_more)
                begin
                    state_next = nfba_pkg::S_F_DONE;
                end
            end
            nfba_pkg::S_F_DONE:   state_next = nfba_pkg::S_DONE;
            nfba_pkg::S_DONE:
            begin
                if (stat.slot_free)
                begin
                    state_next = nfba_pkg::S_IDLE;
                end
            end
            default:              state_next = nfba_pkg::S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        in_ready = 1'b0;
        op       = nfba_pkg::OP_NONE;
        unique case (state_reg)
            nfba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? nfba_pkg::OP_ACCEPT : nfba_pkg::OP_NONE;
            end
            nfba_pkg::S_INIT:     op = nfba_pkg::OP_INIT;
            nfba_pkg::S_DISPATCH: op = nfba_pkg::OP_DISPATCH;
            nfba_pkg::S_A_ROVER:  op = nfba_pkg::OP_A_ROVER;
            nfba_pkg::S_A_SCAN:   op = nfba_pkg::OP_A_SCAN;
            nfba_pkg::S_A_MARK:   op = nfba_pkg::OP_A_MARK;
            nfba_pkg::S_A_SHIFT:  op = nfba_pkg::OP_A_SHIFT;
            nfba_pkg::S_A_SPLIT:  op = nfba_pkg::OP_A_SPLIT;
            nfba_pkg::S_F_SCAN:   op = nfba_pkg::OP_F_SCAN;
            nfba_pkg::S_F_PREV:   op = nfba_pkg::OP_F_PREV;
            nfba_pkg::S_F_NEXT:   op = nfba_pkg::OP_F_NEXT;
            nfba_pkg::S_F_MERGE:  op = nfba_pkg::OP_F_MERGE;
            nfba_pkg::S_F_SHIFT:  op = nfba_pkg::OP_F_SHIFT;
            nfba_pkg::S_F_DONE:   op = nfba_pkg::OP_F_DONE;
            nfba_pkg::S_DONE:
            begin
                op = stat.slot_free ? nfba_pkg::OP_LOAD : nfba_pkg::OP_NONE;
            end
            default:              op = nfba_pkg::OP_NONE;
        endcase
    end

endmodule

@@ src/nfba_dp.sv @@
// datapath of the allocator: block table memory, registers and arithmetic
module nfba_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nfba_pkg::op_t                    op,
    output nfba_pkg::dp_stat_t               stat,
    input  logic                             in_action,
    input  nfba_pkg::size_t                  in_size,
    input  nfba_pkg::addr_t                  in_addr,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output nfba_pkg::addr_t                  out_addr,
    output nfba_pkg::status_t                out_status
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int W1 = CW + 1;

    typedef logic [IW-1:0] idx_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [W1-1:0] wide_t;

    localparam nfba_pkg::size_t HDR   = nfba_pkg::size_t'(HEADER_BYTES);
    localparam nfba_pkg::addr_t HDR_A = nfba_pkg::addr_t'(HEADER_BYTES);
    localparam cnt_t            MAXC  = cnt_t'(MAX_BLOCKS);

    // block table
    nfba_pkg::entry_t mem [MAX_BLOCKS];
    nfba_pkg::entry_t rd_q;
    idx_t             rd_addr;
    logic             wr_en;
    idx_t             wr_addr;
    nfba_pkg::entry_t wr_data;

    // control state
    nfba_pkg::size_t region_size_reg;
    nfba_pkg::addr_t region_base_reg;
    logic            fresh_reg;
    cnt_t            count_reg;
    idx_t            rover_reg;
    logic            out_valid_reg;

    // payload registers
    logic              action_reg;
    nfba_pkg::size_t   want_reg;
    nfba_pkg::addr_t   addr_reg;
    nfba_pkg::addr_t   rel_reg;
    cnt_t              i_reg;
    idx_t              pick_reg;
    idx_t              lo_reg;
    logic [1:0]        gap_reg;
    nfba_pkg::entry_t  cur_reg;
    nfba_pkg::entry_t  prev_reg;
    nfba_pkg::entry_t  nxt_reg;
    logic              prev_free_reg;
    logic              next_free_reg;
    nfba_pkg::addr_t   res_addr_reg;
    nfba_pkg::status_t res_status_reg;
    nfba_pkg::addr_t   out_addr_reg;
    nfba_pkg::status_t out_status_reg;

    // combinational helpers
    idx_t            i_idx;
    idx_t            rover_eff;
    logic            fit;
    logic            scan_end;
    nfba_pkg::size_t rest;
    logic            do_split;
    logic            match;
    idx_t            lo_c;
    logic [1:0]      gap_c;
    nfba_pkg::size_t lo_off;
    nfba_pkg::size_t hi_end;
    nfba_pkg::size_t init_size;
    nfba_pkg::addr_t granted;
    cnt_t            new_count;
    idx_t            rover_free;
    logic            slot_free;
    logic            shift_more;

    assign i_idx     = i_reg[IW-1:0];
    assign rover_eff = (cnt_t'(rover_reg) >= count_reg) ? '0 : rover_reg;
    assign fit       = !rd_q.used && (rd_q.size >= want_reg);
    assign scan_end  = (wide_t'(i_reg) + wide_t'(1)) >= wide_t'(count_reg);
    assign rest      = cur_reg.size - want_reg;
    assign do_split  = (rest > HDR) && (count_reg < MAXC);
    assign match     = (nfba_pkg::addr_t'(rd_q.offset) + HDR_A) == rel_reg;
    assign lo_c      = i_idx - idx_t'(prev_free_reg);
    assign gap_c     = {1'b0, prev_free_reg} + {1'b0, next_free_reg};
    assign lo_off    = prev_free_reg ? prev_reg.offset : cur_reg.offset;
    assign hi_end    = next_free_reg ? (nxt_reg.offset + nxt_reg.size)
                                     : (cur_reg.offset + cur_reg.size);
    assign init_size = (region_size_reg > HDR) ? (region_size_reg - HDR) : '0;
    assign granted   = region_base_reg + nfba_pkg::addr_t'(cur_reg.offset) + HDR_A;
    assign new_count = count_reg - cnt_t'(gap_reg);
    assign slot_free = !out_valid_reg || out_ready;

    // rover after a free: past the used block that follows, else the one before
    always_comb
    begin
        if ((wide_t'(lo_reg) + wide_t'(1)) < wide_t'(new_count))
        begin
            rover_free = ((wide_t'(lo_reg) + wide_t'(2)) < wide_t'(new_count))
                       ? (lo_reg + idx_t'(2)) : '0;
        end
        else
        begin
            rover_free = (lo_reg != '0) ? (lo_reg - idx_t'(1)) : '0;
        end
    end

    // whether a shift sweep has another entry to move
    always_comb
    begin
        unique case (op)
            nfba_pkg::OP_A_MARK:
                shift_more = wide_t'(count_reg) > (wide_t'(pick_reg) + wide_t'(1));
            nfba_pkg::OP_A_SHIFT:
                shift_more = wide_t'(i_reg) > (wide_t'(pick_reg) + wide_t'(2));
            nfba_pkg::OP_F_MERGE:
                shift_more = (gap_c != 2'd0)
                          && ((wide_t'(lo_c) + wide_t'(1) + wide_t'(gap_c))
                              < wide_t'(count_reg));
            nfba_pkg::OP_F_SHIFT:
                shift_more = (wide_t'(i_reg) + wide_t'(1) + wide_t'(gap_reg))
                           < wide_t'(count_reg);
            default:
                shift_more = 1'b0;
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.fresh      = fresh_reg;
        stat.is_free    = (action_reg == nfba_pkg::ACT_FREE);
        stat.want_zero  = (want_reg == '0);
        stat.fit        = fit;
        stat.scan_end   = scan_end;
        stat.do_split   = do_split;
        stat.match      = match;
        stat.used       = rd_q.used;
        stat.shift_more = shift_more;
        stat.slot_free  = slot_free;
    end

    // table read address
    always_comb
    begin
        unique case (op)
            nfba_pkg::OP_DISPATCH:
                rd_addr = (action_reg == nfba_pkg::ACT_FREE) ? '0 : rover_eff;
            nfba_pkg::OP_A_SCAN:   rd_addr = i_idx + idx_t'(1);
            nfba_pkg::OP_A_MARK:   rd_addr = idx_t'(count_reg - cnt_t'(1));
            nfba_pkg::OP_A_SHIFT:  rd_addr = idx_t'(i_reg - cnt_t'(2));
            nfba_pkg::OP_F_SCAN:
                rd_addr = match ? (i_idx - idx_t'(1)) : (i_idx + idx_t'(1));
            nfba_pkg::OP_F_PREV:   rd_addr = i_idx + idx_t'(1);
            nfba_pkg::OP_F_MERGE:  rd_addr = lo_c + idx_t'(1) + idx_t'(gap_c);
            nfba_pkg::OP_F_SHIFT:
                rd_addr = idx_t'(i_reg + cnt_t'(1) + cnt_t'(gap_reg));
            default:               rd_addr = '0;
        endcase
    end

    // table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_idx;
        wr_data = rd_q;
        unique case (op)
            nfba_pkg::OP_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{used: 1'b0, size: init_size, offset: '0};
            end
            nfba_pkg::OP_A_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = '{used: 1'b1, size: (do_split ? want_reg : cur_reg.size),
                            offset: cur_reg.offset};
            end
            nfba_pkg::OP_A_SHIFT:
            begin
                wr_en = 1'b1;
            end
            nfba_pkg::OP_A_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg + idx_t'(1);
                wr_data = '{used: 1'b0, size: rest - HDR,
                            offset: cur_reg.offset + HDR + want_reg};
            end
            nfba_pkg::OP_F_MERGE:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_c;
                wr_data = '{used: 1'b0, size: hi_end - lo_off, offset: lo_off};
            end
            nfba_pkg::OP_F_SHIFT:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // block table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // configuration, table bookkeeping and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= nfba_pkg::REGION_SIZE_RESET;
            region_base_reg <= '0;
            fresh_reg       <= 1'b1;
            count_reg       <= cnt_t'(1);
            rover_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nfba_pkg::CFG_REGION_SIZE:
                    begin
                        region_size_reg <= cfg_data[nfba_pkg::SIZE_W-1:0];
                        fresh_reg       <= 1'b1;
                        count_reg       <= cnt_t'(1);
                        rover_reg       <= '0;
                    end
                    nfba_pkg::CFG_REGION_BASE:
                    begin
                        region_base_reg <= cfg_data;
                    end
                    default:
                    begin
                        region_base_reg <= region_base_reg;
                    end
                endcase
            end
            unique case (op)
                nfba_pkg::OP_INIT:     fresh_reg <= 1'b0;
                nfba_pkg::OP_DISPATCH:
                begin
                    if ((action_reg == nfba_pkg::ACT_ALLOC) && (want_reg != '0))
                    begin
                        rover_reg <= rover_eff;
                    end
                end
                nfba_pkg::OP_A_ROVER:
                begin
                    if (!fit)
                    begin
                        rover_reg <= '0;
                    end
                end
                nfba_pkg::OP_A_SPLIT:
                begin
                    count_reg <= count_reg + cnt_t'(1);
                    rover_reg <= pick_reg + idx_t'(1);
                end
                nfba_pkg::OP_F_DONE:
                begin
                    count_reg <= new_count;
                    rover_reg <= rover_free;
                end
                default:
                begin
                    // other commands leave the bookkeeping alone
                end
            endcase
            if (op == nfba_pkg::OP_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of one item
    always_ff @(posedge clk)
    begin
        unique case (op)
            nfba_pkg::OP_ACCEPT:
            begin
                action_reg <= in_action;
                want_reg   <= in_size;
                addr_reg   <= in_addr;
            end
            nfba_pkg::OP_DISPATCH:
            begin
                i_reg          <= '0;
                rel_reg        <= addr_reg - region_base_reg;
                res_addr_reg   <= '0;
                res_status_reg <= nfba_pkg::ST_ZERO_SIZE;
            end
            nfba_pkg::OP_A_ROVER:
            begin
                pick_reg <= rover_reg;
                cur_reg  <= rd_q;
            end
            nfba_pkg::OP_A_SCAN:
            begin
                pick_reg       <= i_idx;
                cur_reg        <= rd_q;
                i_reg          <= i_reg + cnt_t'(1);
                res_addr_reg   <= '0;
                res_status_reg <= nfba_pkg::ST_NO_FIT;
            end
            nfba_pkg::OP_A_MARK:
            begin
                i_reg          <= count_reg;
                res_addr_reg   <= granted;
                res_status_reg <= nfba_pkg::ST_GRANTED;
            end
            nfba_pkg::OP_A_SHIFT:  i_reg <= i_reg - cnt_t'(1);
            nfba_pkg::OP_F_SCAN:
            begin
                cur_reg        <= rd_q;
                res_addr_reg   <= '0;
                res_status_reg <= nfba_pkg::ST_FREE_IGNORED;
                if (!match)
                begin
                    i_reg <= i_reg + cnt_t'(1);
                end
            end
            nfba_pkg::OP_F_PREV:
            begin
                prev_reg      <= rd_q;
                prev_free_reg <= (i_reg != '0) && !rd_q.used;
            end
            nfba_pkg::OP_F_NEXT:
            begin
                nxt_reg       <= rd_q;
                next_free_reg <= !scan_end && !rd_q.used;
            end
            nfba_pkg::OP_F_MERGE:
            begin
                lo_reg  <= lo_c;
                gap_reg <= gap_c;
                i_reg   <= cnt_t'(lo_c) + cnt_t'(1);
            end
            nfba_pkg::OP_F_SHIFT:  i_reg <= i_reg + cnt_t'(1);
            nfba_pkg::OP_F_DONE:
            begin
                res_addr_reg   <= '0;
                res_status_reg <= nfba_pkg::ST_FREED;
            end
            nfba_pkg::OP_LOAD:
            begin
                out_addr_reg   <= res_addr_reg;
                out_status_reg <= res_status_reg;
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

@@ src/next_fit_block_allocator_top.sv @@
// next-fit block allocator: a table of up to MAX_BLOCKS blocks in one memory
// one item at a time; the table memory gives one read and one write per cycle
// allocate: dispatch, rover try, first-fit scan (up to block count), mark, shift (up to count), split
// free: dispatch, address scan (up to block count), read both neighbours, merge, compaction shift (up to count)
// the first item after reset or size write first writes the first table row
// reset clears control state, so the next item writes one free block spanning the region
module next_fit_block_allocator_top #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // request_size [20:0], block_address [52:21], zero fill above
    input  logic [nfba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action [0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // granted_address [31:0], status [34:32], zero fill above
    output logic [nfba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]  cfg_data
);

    nfba_pkg::dp_stat_t stat;
    nfba_pkg::op_t      op;
    nfba_pkg::addr_t    out_addr;
    nfba_pkg::status_t  out_status;

    nfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .op       (op)
    );

    nfba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .stat       (stat),
        .in_action  (s_axis_tuser),
        .in_size    (s_axis_tdata[20:0]),
        .in_addr    (s_axis_tdata[52:21]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    // result item packing
    assign m_axis_tdata = {5'b0, out_status, out_addr};

endmodule

@@ src/nfba_checker.sv @@
// port-level checks of the allocator, bound to the top level
`include "next_fit_block_allocator_top_defines.svh"

module nfba_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [nfba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result keeps its valid and its payload
    `NFBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `NFBA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // only one item in work at a time
    `NFBA_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // result codes stay in range and only a grant carries an address
    `NFBA_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[34:32] <= 3'd4)
    `NFBA_ASSERT_NOW(a_addr_zero, m_axis_tvalid && (m_axis_tdata[34:32] != 3'd0),
                     m_axis_tdata[31:0] == 32'd0)

endmodule

bind next_fit_block_allocator_top nfba_checker u_nfba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
